### rtl/pcih_pkg.sv
// Shared types and constants for the per-channel interval histogram.
// Holds the queued command record, opcode codes and the state machine types.
// No dependencies.
package pcih_pkg;

  // Microseconds per second, the multiplier in the tick conversion
  localparam logic [19:0] US_PER_S = 20'd1000000;

  // Counter frequency after reset
  localparam logic [31:0] CFG_TPS_RESET = 32'd10000000;

  // Entries in the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Quotient bits kept by the tick converter
  localparam int QUO_W = 41;

  typedef enum logic {
    OP_FLIP = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    F_IDLE,
    F_LOOK
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_DIV,
    B_BMUL,
    B_BFIX,
    B_BSEL,
    B_BRD,
    B_BUPD,
    B_RADDR,
    B_RDATA,
    B_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_MLO,
    D_MHI,
    D_SUM,
    D_CHK,
    D_ITER
  } div_state_t;

  // One classified request, passed from front to back
  typedef struct packed {
    op_t         op;
    logic        gap_valid;
    logic [62:0] gap_ticks;
    logic        lead_neg;
    logic [62:0] lead_ticks;
    logic [6:0]  bin_index;
  } cmd_t;

endpackage

### rtl/pcih_if.sv
// Valid/ready channel interfaces for the interval histogram core.
// Request channel and result channel; no package dependency.
interface pcih_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] head;
  logic [62:0] flip_time;
  logic [62:0] event_time;
  logic [6:0]  bin_index;

  modport source (output valid, opcode, head, flip_time, event_time, bin_index,
                  input ready);
  modport sink   (input valid, opcode, head, flip_time, event_time, bin_index,
                  output ready);
endinterface

interface pcih_out_if;
  logic               valid;
  logic               ready;
  logic signed [40:0] interval_us;
  logic signed [40:0] lead_us;
  logic               binned;
  logic [31:0]        bin_count;
  logic [31:0]        total_intervals;
  logic [47:0]        interval_sum_us;

  modport source (output valid, interval_us, lead_us, binned, bin_count,
                  total_intervals, interval_sum_us, input ready);
  modport sink   (input valid, interval_us, lead_us, binned, bin_count,
                  total_intervals, interval_sum_us, output ready);
endinterface

### rtl/per_channel_interval_histogram_core.sv
// Flip event: the front end and queue hold the classified request, the tick converters
// split multiply and run a 41-step restoring divide, then the gap is binned and emitted;
// an unbinned gap skips the binning states. A bin read goes from address to data to emit.
// One request is in the back end at a time, so the next request is not taken until the
// last result is loaded into the result register; a stalled result holds the back end.
// After reset the histogram memory is cleared with no request taken.
module per_channel_interval_histogram_core #(
  parameter int NUM_HEADS    = 8,
  parameter int NUM_BINS     = 80,
  parameter int BIN_WIDTH_US = 500
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  pcih_in_if.sink     in_chan,
  pcih_out_if.source  out_chan
);

  logic [31:0]    tps_r;
  logic [31:0]    divisor;
  logic           hist_ready;
  logic           push_valid;
  logic           push_ready;
  pcih_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  pcih_pkg::cmd_t pop_cmd;

  // Counter frequency register; zero divides as one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= pcih_pkg::CFG_TPS_RESET;
    end else if (cfg_we) begin
      tps_r <= cfg_wdata;
    end
  end

  assign divisor = (tps_r == 32'd0) ? 32'd1 : tps_r;

  pcih_front #(
    .NUM_HEADS (NUM_HEADS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .hist_ready (hist_ready),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  pcih_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  pcih_back #(
    .NUM_BINS     (NUM_BINS),
    .BIN_WIDTH_US (BIN_WIDTH_US)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .divisor    (divisor),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .hist_ready (hist_ready),
    .out_chan   (out_chan)
  );

endmodule

### rtl/pcih_div.sv
// Tick to microsecond converter: floor(ticks * 1e6 / divisor), 41 quotient bits.
// Split multiply in low and high halves and a sum, overflow check, then one restoring step a cycle.
// Depends on pcih_pkg.
module pcih_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [62:0] ticks,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [40:0] quo,
  output logic        ovf
);

  localparam logic [5:0] LAST_STEP = 6'(pcih_pkg::QUO_W - 1);

  pcih_pkg::div_state_t state_r, state_nxt;

  logic [62:0] t_r;
  logic [31:0] d_r;
  logic [51:0] plo_r;
  logic [50:0] phi_r;
  logic [82:0] n_r;
  logic [31:0] rem_r;
  logic [40:0] q_r;
  logic        ovf_r;
  logic [5:0]  cnt_r;

  logic [32:0] cur;
  logic [32:0] cur_diff;
  logic        cur_ge;
  logic        chk_ovf;

  // One restoring step: bring down the next dividend bit
  assign cur      = {rem_r, n_r[40]};
  assign cur_ge   = cur >= {1'b0, d_r};
  assign cur_diff = cur - {1'b0, d_r};
  // Quotient needs more than 41 bits when the top part already reaches the divisor
  assign chk_ovf  = n_r[82:41] >= {10'd0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcih_pkg::D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcih_pkg::D_IDLE: if (start) state_nxt = pcih_pkg::D_MLO;
      pcih_pkg::D_MLO:  state_nxt = pcih_pkg::D_MHI;
      pcih_pkg::D_MHI:  state_nxt = pcih_pkg::D_SUM;
      pcih_pkg::D_SUM:  state_nxt = pcih_pkg::D_CHK;
      pcih_pkg::D_CHK:  state_nxt = chk_ovf ? pcih_pkg::D_IDLE : pcih_pkg::D_ITER;
      pcih_pkg::D_ITER: if (cnt_r == 6'd0) state_nxt = pcih_pkg::D_IDLE;
      default:          state_nxt = pcih_pkg::D_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      pcih_pkg::D_IDLE: begin
        if (start) begin
          t_r <= ticks;
          d_r <= divisor;
        end
      end
      pcih_pkg::D_MLO: plo_r <= 52'(t_r[31:0]) * 52'(pcih_pkg::US_PER_S);
      pcih_pkg::D_MHI: phi_r <= 51'(t_r[62:32]) * 51'(pcih_pkg::US_PER_S);
      pcih_pkg::D_SUM: n_r <= {phi_r, 32'd0} + 83'(plo_r);
      pcih_pkg::D_CHK: begin
        ovf_r <= chk_ovf;
        rem_r <= n_r[72:41];
        cnt_r <= LAST_STEP;
      end
      pcih_pkg::D_ITER: begin
        rem_r <= cur_ge ? cur_diff[31:0] : cur[31:0];
        q_r   <= {q_r[39:0], cur_ge};
        n_r   <= {n_r[81:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
      end
      default: ;
    endcase
  end

  assign busy = state_r != pcih_pkg::D_IDLE;
  assign quo  = q_r;
  assign ovf  = ovf_r;

endmodule

### rtl/pcih_front.sv
// Front end: accepts requests, looks up the last flip time of the head and
// classifies the request into a queued command. Depends on pcih_pkg, pcih_if.
module pcih_front #(
  parameter int NUM_HEADS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            hist_ready,
  pcih_in_if.sink         in_chan,
  output logic            push_valid,
  input  logic            push_ready,
  output pcih_pkg::cmd_t  push_cmd
);

  localparam int HW = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;

  pcih_pkg::front_state_t state_r, state_nxt;

  logic [62:0]          lft_mem [NUM_HEADS];
  logic [NUM_HEADS-1:0] vld_r;

  pcih_pkg::op_t op_r;
  logic          head_ok_r;
  logic [HW-1:0] hidx_r;
  logic [62:0]   ts_r;
  logic [6:0]    bidx_r;
  logic          lead_neg_r;
  logic [62:0]   lead_ticks_r;
  logic [62:0]   prev_r;
  logic          prev_vld_r;

  logic          accept;
  logic          head_ok;
  logic [HW-1:0] hidx;
  logic          lead_neg;
  logic [62:0]   lead_mag;
  logic [63:0]   gap_diff;
  logic          gap_valid;
  logic          lft_we;

  assign accept   = in_chan.valid && in_chan.ready;
  assign head_ok  = in_chan.head < 32'(NUM_HEADS);
  assign hidx     = in_chan.head[HW-1:0];
  assign lead_neg = in_chan.flip_time < in_chan.event_time;
  assign lead_mag = lead_neg ? (in_chan.event_time - in_chan.flip_time)
                             : (in_chan.flip_time - in_chan.event_time);

  // Gap exists only for a later flip on a tracked head with a stored time
  assign gap_diff  = {1'b0, ts_r} - {1'b0, prev_r};
  assign gap_valid = (op_r == pcih_pkg::OP_FLIP) && head_ok_r && prev_vld_r &&
                     (prev_r != 63'd0) && !gap_diff[63] && (gap_diff[62:0] != 63'd0);

  assign lft_we = (state_r == pcih_pkg::F_LOOK) && push_ready &&
                  (op_r == pcih_pkg::OP_FLIP) && head_ok_r && (ts_r != 63'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcih_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_chan.ready = 1'b0;
    push_valid    = 1'b0;
    case (state_r)
      pcih_pkg::F_IDLE: begin
        in_chan.ready = hist_ready;
        if (accept) state_nxt = pcih_pkg::F_LOOK;
      end
      pcih_pkg::F_LOOK: begin
        push_valid = 1'b1;
        if (push_ready) state_nxt = pcih_pkg::F_IDLE;
      end
      default: state_nxt = pcih_pkg::F_IDLE;
    endcase
  end

  // Hold the request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= pcih_pkg::op_t'(in_chan.opcode);
      head_ok_r    <= head_ok;
      hidx_r       <= hidx;
      ts_r         <= in_chan.flip_time;
      bidx_r       <= in_chan.bin_index;
      lead_neg_r   <= lead_neg;
      lead_ticks_r <= lead_mag;
      prev_vld_r   <= head_ok && vld_r[hidx];
    end
  end

  // Last flip time per head: registered read, write on hand-off
  always_ff @(posedge clk) begin
    if (accept && head_ok) prev_r <= lft_mem[hidx];
    if (lft_we) lft_mem[hidx_r] <= ts_r;
  end

  // Mark heads that hold a time; an unmarked head reads as no previous flip
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (lft_we) begin
      vld_r[hidx_r] <= 1'b1;
    end
  end

  // Pass a zero gap when there is none, so the converter never sees an unset time
  always_comb begin
    push_cmd.op         = op_r;
    push_cmd.gap_valid  = gap_valid;
    push_cmd.gap_ticks  = gap_valid ? gap_diff[62:0] : '0;
    push_cmd.lead_neg   = lead_neg_r;
    push_cmd.lead_ticks = lead_ticks_r;
    push_cmd.bin_index  = bidx_r;
  end

endmodule

### rtl/pcih_queue.sv
// Short command queue between front and back ends.
// Depends on pcih_pkg for the command record and depth.
module pcih_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  pcih_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pcih_pkg::cmd_t pop_cmd
);

  localparam int PW = (pcih_pkg::QUEUE_DEPTH > 1) ? $clog2(pcih_pkg::QUEUE_DEPTH) : 1;
  localparam logic [PW:0] FULL = (PW + 1)'(pcih_pkg::QUEUE_DEPTH);

  pcih_pkg::cmd_t slot_r [pcih_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    cnt_r;

  logic do_push;
  logic do_pop;

  assign push_ready = cnt_r != FULL;
  assign pop_valid  = cnt_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

  // Pointers wrap at the power-of-two depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + (PW + 1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (PW + 1)'(1);
    end
  end

endmodule

### rtl/pcih_back.sv
// Back end: converts gaps and leads to microseconds, bins the gap into the
// histogram memory and drives the result register. Depends on pcih_pkg,
// pcih_if and pcih_div.
module pcih_back #(
  parameter int NUM_BINS     = 80,
  parameter int BIN_WIDTH_US = 500
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    divisor,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  pcih_pkg::cmd_t pop_cmd,
  output logic           hist_ready,
  pcih_out_if.source     out_chan
);

  localparam int LIMIT = NUM_BINS * BIN_WIDTH_US;
  localparam int RW    = $clog2(LIMIT + 1);
  localparam int BIW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int QW    = $clog2(NUM_BINS + 1);
  localparam longint unsigned RECIP = (64'd1 << RW) / BIN_WIDTH_US;
  localparam logic [RW:0]    RECIP_C  = (RW + 1)'(RECIP);
  localparam logic [RW-1:0]  WIDTH_C  = RW'(BIN_WIDTH_US);
  localparam logic [39:0]    LIMIT_C  = 40'(LIMIT);
  localparam logic [BIW-1:0] LAST_BIN = BIW'(NUM_BINS - 1);

  pcih_pkg::back_state_t state_r, state_nxt;
  pcih_pkg::cmd_t        cmd_r;

  logic [31:0]    hist_mem [NUM_BINS];
  logic [31:0]    mem_q_r;
  logic [BIW-1:0] mem_addr;
  logic           mem_re;
  logic           mem_we;
  logic [31:0]    mem_wdata;

  logic [BIW-1:0] clr_cnt_r;
  logic [39:0]    gap_us_r;
  logic [2*RW:0]  prod_r;
  logic [QW-1:0]  qe_r;
  logic [RW-1:0]  rem_r;
  logic [BIW-1:0] bin_r;
  logic [31:0]    total_r;
  logic [47:0]    sum_r;

  logic signed [40:0] res_interval_r;
  logic signed [40:0] res_lead_r;
  logic               res_binned_r;
  logic [31:0]        res_count_r;

  logic               out_valid_r;
  logic signed [40:0] out_interval_r;
  logic signed [40:0] out_lead_r;
  logic               out_binned_r;
  logic [31:0]        out_count_r;
  logic [31:0]        out_total_r;
  logic [47:0]        out_sum_r;

  logic        div_start;
  logic        g_busy, l_busy;
  logic [40:0] g_quo, l_quo;
  logic        g_ovf, l_ovf;
  logic        load_out;

  logic [39:0]   gap_us;
  logic [40:0]   l_pos;
  logic [40:0]   l_mag;
  logic [40:0]   lead_val;
  logic          in_range;
  logic [RW-1:0] us_lo;
  logic [QW-1:0] q_est;
  logic          bidx_ok;
  logic [QW-1:0] bin_q;
  logic [31:0]   bin_inc;
  logic [48:0]   sum_ext;
  logic [47:0]   sum_nxt;

  pcih_div u_gap_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .ticks   (pop_cmd.gap_ticks),
    .divisor (divisor),
    .busy    (g_busy),
    .quo     (g_quo),
    .ovf     (g_ovf)
  );

  pcih_div u_lead_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .ticks   (pop_cmd.lead_ticks),
    .divisor (divisor),
    .busy    (l_busy),
    .quo     (l_quo),
    .ovf     (l_ovf)
  );

  // Saturate the converted gap and lead
  assign gap_us   = (g_ovf || g_quo[40]) ? '1 : g_quo[39:0];
  assign l_pos    = (l_ovf || l_quo[40]) ? {1'b0, 40'hFF_FFFF_FFFF} : {1'b0, l_quo[39:0]};
  assign l_mag    = (l_ovf || (l_quo[40] && (l_quo[39:0] != 40'd0))) ? {1'b1, 40'd0} : l_quo;
  assign lead_val = cmd_r.lead_neg ? (~l_mag + 41'd1) : l_pos;
  assign in_range = cmd_r.gap_valid && (gap_us < LIMIT_C);

  // Bin number by reciprocal multiply; the estimate is at most one low
  assign us_lo   = gap_us_r[RW-1:0];
  assign q_est   = prod_r[RW +: QW];
  assign bin_q   = (rem_r >= WIDTH_C) ? (qe_r + QW'(1)) : qe_r;
  assign bidx_ok = {25'd0, cmd_r.bin_index} < 32'(NUM_BINS);

  assign bin_inc = (mem_q_r == '1) ? mem_q_r : (mem_q_r + 32'd1);
  assign sum_ext = {1'b0, sum_r} + {9'd0, gap_us_r};
  assign sum_nxt = sum_ext[48] ? '1 : sum_ext[47:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcih_pkg::B_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop_ready = 1'b0;
    div_start = 1'b0;
    mem_addr  = bin_r;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = bin_inc;
    load_out  = 1'b0;
    case (state_r)
      pcih_pkg::B_CLEAR: begin
        mem_addr  = clr_cnt_r;
        mem_we    = 1'b1;
        mem_wdata = 32'd0;
        if (clr_cnt_r == LAST_BIN) state_nxt = pcih_pkg::B_IDLE;
      end
      pcih_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_cmd.op == pcih_pkg::OP_READ) begin
            state_nxt = pcih_pkg::B_RADDR;
          end else begin
            div_start = 1'b1;
            state_nxt = pcih_pkg::B_DIV;
          end
        end
      end
      pcih_pkg::B_DIV: begin
        if (!g_busy && !l_busy) state_nxt = in_range ? pcih_pkg::B_BMUL : pcih_pkg::B_EMIT;
      end
      pcih_pkg::B_BMUL: state_nxt = pcih_pkg::B_BFIX;
      pcih_pkg::B_BFIX: state_nxt = pcih_pkg::B_BSEL;
      pcih_pkg::B_BSEL: state_nxt = pcih_pkg::B_BRD;
      pcih_pkg::B_BRD: begin
        mem_re    = 1'b1;
        state_nxt = pcih_pkg::B_BUPD;
      end
      pcih_pkg::B_BUPD: begin
        mem_we    = 1'b1;
        state_nxt = pcih_pkg::B_EMIT;
      end
      pcih_pkg::B_RADDR: begin
        mem_addr  = BIW'(cmd_r.bin_index);
        mem_re    = bidx_ok;
        state_nxt = pcih_pkg::B_RDATA;
      end
      pcih_pkg::B_RDATA: state_nxt = pcih_pkg::B_EMIT;
      pcih_pkg::B_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = pcih_pkg::B_IDLE;
        end
      end
      default: state_nxt = pcih_pkg::B_IDLE;
    endcase
  end

  // Histogram memory, registered read
  always_ff @(posedge clk) begin
    if (mem_re) mem_q_r <= hist_mem[mem_addr];
    if (mem_we) hist_mem[mem_addr] <= mem_wdata;
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state_r)
      pcih_pkg::B_IDLE: begin
        if (pop_valid) begin
          cmd_r          <= pop_cmd;
          res_interval_r <= '1;
          res_lead_r     <= '0;
          res_binned_r   <= 1'b0;
          res_count_r    <= '0;
        end
      end
      pcih_pkg::B_DIV: begin
        if (!g_busy && !l_busy) begin
          gap_us_r       <= gap_us;
          res_interval_r <= cmd_r.gap_valid ? $signed({1'b0, gap_us}) : '1;
          res_lead_r     <= $signed(lead_val);
        end
      end
      pcih_pkg::B_BMUL: prod_r <= (2 * RW + 1)'(us_lo) * (2 * RW + 1)'(RECIP_C);
      pcih_pkg::B_BFIX: begin
        qe_r  <= q_est;
        rem_r <= us_lo - RW'(RW'(q_est) * WIDTH_C);
      end
      pcih_pkg::B_BSEL:  bin_r <= BIW'(bin_q);
      pcih_pkg::B_BUPD:  res_binned_r <= 1'b1;
      pcih_pkg::B_RDATA: res_count_r <= bidx_ok ? mem_q_r : 32'd0;
      default: ;
    endcase
  end

  // Clear sweep counter and running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      total_r   <= '0;
      sum_r     <= '0;
    end else begin
      if (state_r == pcih_pkg::B_CLEAR) clr_cnt_r <= clr_cnt_r + BIW'(1);
      if (state_r == pcih_pkg::B_BUPD) begin
        if (total_r != '1) total_r <= total_r + 32'd1;
        sum_r <= sum_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_interval_r <= res_interval_r;
      out_lead_r     <= res_lead_r;
      out_binned_r   <= res_binned_r;
      out_count_r    <= res_count_r;
      out_total_r    <= total_r;
      out_sum_r      <= sum_r;
    end
  end

  assign hist_ready               = state_r != pcih_pkg::B_CLEAR;
  assign out_chan.valid           = out_valid_r;
  assign out_chan.interval_us     = out_interval_r;
  assign out_chan.lead_us         = out_lead_r;
  assign out_chan.binned          = out_binned_r;
  assign out_chan.bin_count       = out_count_r;
  assign out_chan.total_intervals = out_total_r;
  assign out_chan.interval_sum_us = out_sum_r;

endmodule
